// ===== hw/rtl/cspw_pkg.sv =====
// Package for the clipped span pixel writer.
// Holds pixel format codes, register indexes, controller/datapath structs and color helpers.
// No dependencies.
package cspw_pkg;

  localparam int SpanPixelsDefault = 32;
  localparam int MaskBits = 32;
  localparam int CoordW = 13;
  localparam int DimW = 12;

  typedef enum logic [1:0] {
    FMT_8BPP  = 2'd0,
    FMT_16BPP = 2'd1,
    FMT_32BPP = 2'd2,
    FMT_NONE  = 2'd3
  } pix_fmt_t;

  typedef enum logic [1:0] {
    REG_FRAME_BASE    = 2'd0,
    REG_SCREEN_WIDTH  = 2'd1,
    REG_SCREEN_HEIGHT = 2'd2,
    REG_PIXEL_FORMAT  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic load;
    logic mult;
    logic base;
    logic step;
  } dp_cmd_t;

  typedef struct packed {
    logic any;
    logic cur_bit;
    logic rest_empty;
    logic slot_free;
  } dp_stat_t;

  function automatic logic [15:0] to_rgb565(input logic [31:0] color);
    to_rgb565 = {color[23:19], color[15:10], color[7:3]};
  endfunction

  function automatic logic [31:0] format_color(input pix_fmt_t fmt, input logic [31:0] color);
    case (fmt)
      FMT_8BPP:  format_color = {24'd0, color[7:0]};
      FMT_16BPP: format_color = {16'd0, to_rgb565(color)};
      FMT_32BPP: format_color = color;
      default:   format_color = 32'd0;
    endcase
  endfunction

endpackage

// ===== hw/rtl/cspw_regs.sv =====
// Configuration register bank of the clipped span pixel writer.
// APB-style write and read access; depends on cspw_pkg.
module cspw_regs
  import cspw_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [3:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  output logic [31:0]     frame_base,
  output logic [DimW-1:0] screen_width,
  output logic [DimW-1:0] screen_height,
  output pix_fmt_t        pixel_format
);

  logic [31:0]     frame_base_r;
  logic [DimW-1:0] screen_width_r;
  logic [DimW-1:0] screen_height_r;
  pix_fmt_t        pixel_format_r;
  logic            wr_en;
  reg_idx_t        idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r    <= 32'd0;
      screen_width_r  <= DimW'(800);
      screen_height_r <= DimW'(480);
      pixel_format_r  <= FMT_16BPP;
    end else if (wr_en) begin
      case (idx)
        REG_FRAME_BASE:    frame_base_r    <= pwdata;
        REG_SCREEN_WIDTH:  screen_width_r  <= pwdata[DimW-1:0];
        REG_SCREEN_HEIGHT: screen_height_r <= pwdata[DimW-1:0];
        REG_PIXEL_FORMAT:  pixel_format_r  <= pix_fmt_t'(pwdata[1:0]);
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_BASE:    prdata = frame_base_r;
      REG_SCREEN_WIDTH:  prdata = {20'd0, screen_width_r};
      REG_SCREEN_HEIGHT: prdata = {20'd0, screen_height_r};
      REG_PIXEL_FORMAT:  prdata = {30'd0, pixel_format_r};
      default:           prdata = 32'd0;
    endcase
  end

  assign frame_base    = frame_base_r;
  assign screen_width  = screen_width_r;
  assign screen_height = screen_height_r;
  assign pixel_format  = pixel_format_r;

endmodule

// ===== hw/rtl/cspw_ctrl.sv =====
// Controller state machine of the clipped span pixel writer.
// Sequences row capture, row offset multiply, start address and the pixel walk; uses cspw_pkg.
module cspw_ctrl
  import cspw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t st
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MULT = 4'b0010,
    ST_BASE = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd.load  = (state_r == ST_IDLE) && in_valid;
    cmd.mult  = (state_r == ST_MULT);
    cmd.base  = (state_r == ST_BASE);
    cmd.step  = (state_r == ST_EMIT) && (!st.cur_bit || st.slot_free);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MULT;
      end
      ST_MULT: begin
        state_nxt = st.any ? ST_BASE : ST_IDLE;
      end
      ST_BASE: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.step && st.rest_empty) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_idle_no_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !st.any)
    else $error("pixels left pending while idle");

  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && !st.any) |-> 1'b0)
    else $error("pixel walk running with no pixels left");

endmodule

// ===== hw/rtl/cspw_dp.sv =====
// Datapath of the clipped span pixel writer.
// Clips the row into a pixel vector, forms addresses and holds the output register; uses cspw_pkg.
module cspw_dp
  import cspw_pkg::*;
#(
  parameter int SPAN_PIXELS = SpanPixelsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          st,
  input  logic [31:0]       frame_base,
  input  logic [DimW-1:0]   screen_width,
  input  logic [DimW-1:0]   screen_height,
  input  pix_fmt_t          pixel_format,
  input  logic              action,
  input  logic [CoordW-1:0] start_x,
  input  logic [CoordW-1:0] row_y,
  input  logic [5:0]        span_width,
  input  logic [31:0]       pixel_mask,
  input  logic [31:0]       color,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       write_address,
  output logic [31:0]       write_data,
  output logic [1:0]        write_size,
  output logic              last_write
);

  localparam int PixW = (SPAN_PIXELS > 1) ? $clog2(SPAN_PIXELS) : 1;

  logic [SPAN_PIXELS-1:0] draw_r, draw_nxt;
  logic [PixW-1:0]        pix_r;
  logic [CoordW-1:0]      x0_r;
  logic [DimW-1:0]        y_r;
  logic [31:0]            data_r;
  pix_fmt_t               fmt_r;
  logic [2*DimW-1:0]      prod_r;
  logic [31:0]            start_addr_r;
  logic                   out_valid_r;
  logic [31:0]            out_addr_r;
  logic [31:0]            out_data_r;
  logic [1:0]             out_size_r;
  logic                   out_last_r;
  logic                   item_ok;
  logic                   emit;
  logic [31:0]            row_off;

  assign item_ok = (pixel_format != FMT_NONE) && !row_y[CoordW-1] &&
                   (row_y[DimW-1:0] < screen_height);

  always_comb begin
    logic signed [CoordW:0] xs;
    logic                   mbit;
    draw_nxt = '0;
    for (int p = 0; p < SPAN_PIXELS; p++) begin
      xs   = $signed({start_x[CoordW-1], start_x}) + $signed((CoordW+1)'(p));
      mbit = (p < MaskBits) ? pixel_mask[5'(p)] : 1'b0;
      draw_nxt[p] = item_ok && (7'(p) < {1'b0, span_width}) && (action || mbit) &&
                    !xs[CoordW] && (xs[CoordW-1:0] < {1'b0, screen_width});
    end
  end

  assign st.any        = |draw_r;
  assign st.cur_bit    = draw_r[0];
  assign st.rest_empty = ~|(draw_r >> 1);
  assign st.slot_free  = !out_valid_r || out_ready;

  assign emit    = cmd.step && draw_r[0];
  assign row_off = 32'(prod_r) + {{(32-CoordW){x0_r[CoordW-1]}}, x0_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      draw_r <= '0;
    end else if (cmd.load) begin
      draw_r <= draw_nxt;
    end else if (cmd.step) begin
      draw_r <= draw_r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_r  <= '0;
      x0_r   <= start_x;
      y_r    <= row_y[DimW-1:0];
      data_r <= format_color(pixel_format, color);
      fmt_r  <= pixel_format;
    end else if (cmd.step) begin
      pix_r <= pix_r + PixW'(1);
    end
    if (cmd.mult) begin
      prod_r <= y_r * screen_width;
    end
    if (cmd.base) begin
      start_addr_r <= frame_base + (row_off << fmt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_addr_r <= start_addr_r + (32'(pix_r) << fmt_r);
      out_data_r <= data_r;
      out_size_r <= fmt_r;
      out_last_r <= st.rest_empty;
    end
  end

  assign out_valid     = out_valid_r;
  assign write_address = out_addr_r;
  assign write_data    = out_data_r;
  assign write_size    = out_size_r;
  assign last_write    = out_last_r;

  a_emit_slot: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_valid_r || out_ready))
    else $error("write issued over an untaken request");

  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> out_valid_r)
    else $error("issued write not presented");

  a_load_clean: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(|draw_r))
    else $error("new row captured while pixels remain");

endmodule

// ===== hw/rtl/clipped_span_pixel_writer.sv =====
// Top level of the clipped span pixel writer.
// Instantiates cspw_regs, cspw_ctrl and cspw_dp; uses cspw_pkg.
//
// Each input request describes one horizontal row of up to SPAN_PIXELS pixels.
// The block turns it into one frame-buffer write request per drawn pixel that
// lies on the screen, in order of rising x, with tlast on the final write.
// The APB port sets frame base, screen size and pixel format; the user must
// write it only while the block is idle, which the block does not enforce.
// Sequence: a row is accepted when in_tready is high, which holds only between
// rows. The row offset multiply follows, then the start address, then the pixel
// walk covers one pixel position per cycle up to the last drawn pixel, held while
// a drawn pixel waits for a free output register. A row that writes nothing goes
// back to idle after the multiply, with no start address and no walk. Undrawn
// positions before the first drawn pixel delay the first write.
// The output register lets the next row be accepted while the last write still
// waits; a stalled receiver holds the walk one pixel at a time.
// Reset loads frame base 0, 800 by 480 pixels and 16 bpp, and clears all
// pending work.
module clipped_span_pixel_writer
  import cspw_pkg::*;
#(
  parameter int SPAN_PIXELS = SpanPixelsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,  // start_x[12:0], row_y[25:13], span_width[31:26],
                                 // pixel_mask[63:32], color[95:64]
  input  logic        in_tuser,  // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata, // write_address[31:0], write_data[63:32]
  output logic [1:0]  out_tuser, // write_size
  output logic        out_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0]     frame_base;
  logic [DimW-1:0] screen_width;
  logic [DimW-1:0] screen_height;
  pix_fmt_t        pixel_format;
  dp_cmd_t         cmd;
  dp_stat_t        st;
  logic [31:0]     write_address;
  logic [31:0]     write_data;

  cspw_regs u_regs (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .frame_base    (frame_base),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .pixel_format  (pixel_format)
  );

  cspw_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cmd      (cmd),
    .st       (st)
  );

  cspw_dp #(
    .SPAN_PIXELS (SPAN_PIXELS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .st            (st),
    .frame_base    (frame_base),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .pixel_format  (pixel_format),
    .action        (in_tuser),
    .start_x       (in_tdata[12:0]),
    .row_y         (in_tdata[25:13]),
    .span_width    (in_tdata[31:26]),
    .pixel_mask    (in_tdata[63:32]),
    .color         (in_tdata[95:64]),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .write_address (write_address),
    .write_data    (write_data),
    .write_size    (out_tuser),
    .last_write    (out_tlast)
  );

  assign out_tdata = {write_data, write_address};

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for clipped_span_pixel_writer: drives row requests and APB register writes,
// and checks every frame-buffer write against a predictor of the row expansion.
// Depends on cspw_pkg and the RTL of the block only.
module tb;
  import cspw_pkg::*;

  localparam logic ACT_GLYPH = 1'b0;
  localparam logic ACT_FILL  = 1'b1;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam int DRAIN_CYCLES = 40;
  localparam int N_DIRECTED = 18;
  localparam int N_PHASES = 7;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} row_check_t;

  typedef struct packed {
    logic               action;
    logic signed [12:0] start_x;
    logic signed [12:0] row_y;
    logic [5:0]         span_width;
    logic [31:0]        mask;
    logic [31:0]        color;
    row_check_t         chk;
    logic [31:0]        t_addr;
    logic [31:0]        t_data;
  } span_row_t;

  typedef struct packed {
    logic [31:0] addr;
    logic [31:0] data;
    logic [1:0]  size;
    logic        last;
  } fb_write_t;

  typedef struct packed {
    logic [31:0] base;
    logic [11:0] width;
    logic [11:0] height;
    pix_fmt_t    fmt;
    logic [7:0]  n_rows;
  } screen_setup_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;   // start_x, row_y, span_width, pixel_mask, color
  logic        in_tuser = 1'b0; // action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // write_address, write_data
  logic [1:0]  out_tuser;       // write_size
  logic        out_tlast;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] cur_base = 32'd0;
  logic [11:0] cur_width = 12'd800;
  logic [11:0] cur_height = 12'd480;
  pix_fmt_t    cur_fmt = FMT_16BPP;

  fb_write_t   pending_writes[$];
  int          errors = 0;
  logic        idle_on = 1'b1;
  int          stall_left = 0;

  span_row_t     directed_rows [N_DIRECTED];
  screen_setup_t setups [N_PHASES];

  clipped_span_pixel_writer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void expand_row_writes(input span_row_t r);
    int          xi;
    int          yi;
    int          n;
    logic [31:0] bytes;
    logic [31:0] data;
    logic [1:0]  size;
    logic [31:0] off;
    logic        drawn;
    logic        have_held;
    fb_write_t   held;
    n = (r.span_width > 6'd32) ? 32 : int'(r.span_width);
    yi = {{19{r.row_y[12]}}, r.row_y};
    have_held = 1'b0;
    held = '0;
    case (cur_fmt)
      FMT_8BPP: begin
        bytes = 32'd1; size = SIZE_BYTE; data = {24'd0, r.color[7:0]};
      end
      FMT_16BPP: begin
        bytes = 32'd2; size = SIZE_HALF;
        data = {16'd0, r.color[23:19], r.color[15:10], r.color[7:3]};
      end
      FMT_32BPP: begin
        bytes = 32'd4; size = SIZE_WORD; data = r.color;
      end
      default: return;
    endcase
    if (yi < 0 || yi >= int'(cur_height)) return;
    for (int p = 0; p < n; p++) begin
      xi = {{19{r.start_x[12]}}, r.start_x} + p;
      drawn = (r.action == ACT_FILL) ? 1'b1 : r.mask[p];
      if (drawn && xi >= 0 && xi < int'(cur_width)) begin
        if (have_held) pending_writes.push_back(held);
        off = (32'(yi) * {20'd0, cur_width} + 32'(xi)) * bytes;
        held = '{addr: cur_base + off, data: data, size: size, last: 1'b0};
        have_held = 1'b1;
      end
    end
    if (have_held) begin
      held.last = 1'b1;
      pending_writes.push_back(held);
    end
  endfunction

  function automatic span_row_t make_random_row();
    span_row_t r;
    int        xi;
    int        yi;
    r = '0;
    r.chk = CHK_MODEL;
    r.action = 1'($urandom_range(0, 1));
    r.color = $urandom;
    if ($urandom_range(0, 9) < 2) begin
      r.start_x = 13'($urandom_range(0, 8191));
      r.row_y = 13'($urandom_range(0, 8191));
    end else begin
      xi = int'($urandom_range(0, int'(cur_width) + 44)) - 36;
      yi = int'($urandom_range(0, int'(cur_height) + 5)) - 3;
      r.start_x = 13'(xi);
      r.row_y = 13'(yi);
    end
    if ($urandom_range(0, 9) == 0) r.span_width = 6'($urandom_range(0, 63));
    else r.span_width = 6'($urandom_range(1, 32));
    case ($urandom_range(0, 9))
      0: r.mask = 32'hFFFF_FFFF;
      1: r.mask = 32'd0;
      default: r.mask = $urandom;
    endcase
    return r;
  endfunction

  task automatic send_row(input span_row_t r);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = r.action;
    in_tdata = {r.color, r.mask, r.span_width, r.row_y, r.start_x};
    do @(posedge clk); while (!in_tready);
    case (r.chk)
      CHK_MODEL: expand_row_writes(r);
      CHK_ONE: pending_writes.push_back('{addr: r.t_addr, data: r.t_data,
                                          size: SIZE_HALF, last: 1'b1});
      default: ;
    endcase
  endtask

  task automatic drain_writes();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_access(input reg_idx_t idx, input logic wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = wr;
    paddr = {idx, 2'b00};
    pwdata = wdata;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic set_reg(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] rd;
    apb_access(idx, 1'b1, value, rd);
    apb_access(idx, 1'b0, 32'd0, rd);
    if (rd !== value) begin
      errors++;
      $error("%s readback: expected %h, got %h", idx.name(), value, rd);
    end
    case (idx)
      REG_FRAME_BASE:    cur_base = value;
      REG_SCREEN_WIDTH:  cur_width = value[11:0];
      REG_SCREEN_HEIGHT: cur_height = value[11:0];
      REG_PIXEL_FORMAT:  cur_fmt = pix_fmt_t'(value[1:0]);
      default: ;
    endcase
  endtask

  always @(negedge clk) begin
    if (!idle_on) begin
      out_tready = 1'b1;
    end else if (stall_left > 0) begin
      out_tready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      out_tready = 1'b0;
      stall_left = $urandom_range(1, 11) - 1;
    end else begin
      out_tready = 1'b1;
    end
  end

  always @(posedge clk) begin : check_writes
    fb_write_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_writes.size() == 0) begin
        errors++;
        $error("unexpected write: address %h, data %h", out_tdata[31:0], out_tdata[63:32]);
      end else begin
        want = pending_writes.pop_front();
        if (out_tdata[31:0] !== want.addr) begin
          errors++;
          $error("write_address: expected %h, got %h", want.addr, out_tdata[31:0]);
        end
        if (out_tdata[63:32] !== want.data) begin
          errors++;
          $error("write_data: expected %h, got %h", want.data, out_tdata[63:32]);
        end
        if (out_tuser !== want.size) begin
          errors++;
          $error("write_size: expected %0d, got %0d", want.size, out_tuser);
        end
        if (out_tlast !== want.last) begin
          errors++;
          $error("last_write: expected %0d, got %0d", want.last, out_tlast);
        end
      end
    end
  end

  initial begin
    // Rows that write nothing are off screen, of zero width, with an empty mask or wholly clipped.
    directed_rows = '{
      '{ACT_FILL,  13'sd0,     13'sd0,     6'd1,  32'd0, 32'h00FF_FFFF, CHK_ONE,
         32'h0000_0000, 32'h0000_FFFF},
      '{ACT_FILL,  13'sd1,     13'sd0,     6'd1,  32'd0, 32'h00F8_0000, CHK_ONE,
         32'h0000_0002, 32'h0000_F800},
      '{ACT_FILL,  13'sd2,     13'sd0,     6'd1,  32'd0, 32'h0000_FC00, CHK_ONE,
         32'h0000_0004, 32'h0000_07E0},
      '{ACT_FILL,  13'sd3,     13'sd0,     6'd1,  32'd0, 32'h0000_00F8, CHK_ONE,
         32'h0000_0006, 32'h0000_001F},
      '{ACT_FILL,  13'sd799,   13'sd479,   6'd1,  32'd0, 32'hFF00_0000, CHK_ONE,
         32'h000B_B7FE, 32'h0000_0000},
      '{ACT_GLYPH, 13'sd0,     13'sd0,     6'd1,  32'd0, 32'h00FF_FFFF, CHK_NONE, 32'd0, 32'd0},
      '{ACT_FILL,  -13'sd1,    13'sd0,     6'd1,  32'd0, 32'h0012_3456, CHK_NONE, 32'd0, 32'd0},
      '{ACT_FILL,  13'sd800,   13'sd5,     6'd1,  32'd0, 32'h0012_3456, CHK_NONE, 32'd0, 32'd0},
      '{ACT_FILL,  13'sd0,     -13'sd1,    6'd1,  32'd0, 32'h0012_3456, CHK_NONE, 32'd0, 32'd0},
      '{ACT_FILL,  13'sd0,     13'sd480,   6'd32, 32'd0, 32'h0012_3456, CHK_NONE, 32'd0, 32'd0},
      '{ACT_FILL,  -13'sd4096, -13'sd4096, 6'd32, 32'hFFFF_FFFF, 32'hFFFF_FFFF, CHK_NONE,
         32'd0, 32'd0},
      '{ACT_FILL,  13'sd4095,  13'sd4095,  6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, CHK_NONE,
         32'd0, 32'd0},
      '{ACT_FILL,  13'sd10,    13'sd10,    6'd0,  32'hFFFF_FFFF, 32'h00AB_CDEF, CHK_NONE,
         32'd0, 32'd0},
      '{ACT_FILL,  13'sd0,     13'sd1,     6'd63, 32'd0, 32'h0055_AA55, CHK_MODEL, 32'd0, 32'd0},
      '{ACT_GLYPH, -13'sd5,    13'sd2,     6'd32, 32'hAAAA_AAAA, 32'h00C0_FFEE, CHK_MODEL,
         32'd0, 32'd0},
      '{ACT_GLYPH, 13'sd790,   13'sd10,    6'd32, 32'hFFFF_FFFF, 32'h0080_8080, CHK_MODEL,
         32'd0, 32'd0},
      '{ACT_GLYPH, 13'sd100,   13'sd20,    6'd40, 32'h8000_0001, 32'h0001_0203, CHK_MODEL,
         32'd0, 32'd0},
      '{ACT_GLYPH, 13'sd0,     13'sd479,   6'd32, 32'h8000_0000, 32'h00FF_00FF, CHK_MODEL,
         32'd0, 32'd0}
    };
    setups = '{
      '{32'hFFFF_FFF0, 12'd4095, 12'd4095, FMT_32BPP, 8'd35},
      '{32'h0000_0100, 12'd1,    12'd2,    FMT_8BPP,  8'd25},
      '{32'h1000_0000, 12'd37,   12'd20,   FMT_16BPP, 8'd40},
      '{32'h0000_0000, 12'd100,  12'd100,  FMT_NONE,  8'd10},
      '{32'h0000_0000, 12'd0,    12'd50,   FMT_16BPP, 8'd10},
      '{32'h8000_0000, 12'd64,   12'd0,    FMT_8BPP,  8'd8},
      '{32'h8765_4320, 12'd64,   12'd48,   FMT_32BPP, 8'd60}
    };

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) send_row(directed_rows[i]);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain_writes();
      set_reg(REG_FRAME_BASE, setups[ph].base);
      set_reg(REG_SCREEN_WIDTH, {20'd0, setups[ph].width});
      set_reg(REG_SCREEN_HEIGHT, {20'd0, setups[ph].height});
      set_reg(REG_PIXEL_FORMAT, {30'd0, setups[ph].fmt});
      if (ph == N_PHASES - 1) idle_on = 1'b0;
      for (int i = 0; i < int'(setups[ph].n_rows); i++) begin
        if (ph == 2 && i == 20) drain_writes();
        send_row(make_random_row());
      end
    end

    drain_writes();
    if (errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("tb NOT OK");
    $finish;
  end

endmodule
